FILE: design/renv_pkg.sv
package renv_pkg;

  typedef struct packed {
    logic [1:0] func;
    logic [9:0] delta_ms;
  } renv_in_t;

  typedef struct packed {
    logic [15:0] level;
    logic        report;
    logic        running;
  } renv_out_t;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } renv_div_stat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TIME,
    ST_EVAL,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } renv_state_t;

  localparam logic [1:0] FUNC_TICK = 2'd0;
  localparam logic [1:0] FUNC_ARM  = 2'd1;
  localparam logic [1:0] FUNC_STOP = 2'd2;

  localparam logic [2:0] CFG_START_LEVEL  = 3'd0;
  localparam logic [2:0] CFG_PEAK_LEVEL   = 3'd1;
  localparam logic [2:0] CFG_RISE_TIME    = 3'd2;
  localparam logic [2:0] CFG_END_TIME     = 3'd3;
  localparam logic [2:0] CFG_REPEAT_COUNT = 3'd4;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int REPEAT_W    = 8;
  localparam int DELTA_W     = 10;
  localparam int OUT_LEVEL_W = 16;
  localparam int UNITY_RAW   = 4096;

endpackage

FILE: design/renv_div.sv
module renv_div #(
  parameter int QW = 16,
  parameter int DW = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [QW+DW-1:0]           dividend,
  input  logic [DW-1:0]              divisor,
  output logic [QW-1:0]              quotient,
  output renv_pkg::renv_div_stat_t   stat
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem_r;
  logic [DW-1:0] den_r;
  logic [QW-1:0] quo_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          done_r;
  logic [DW:0]   trial;
  logic [DW:0]   trial_sub;
  logic          fits;

  // Restoring division, one quotient bit per cycle. The caller guarantees
  // the quotient fits in QW bits, so the upper dividend bits start as the
  // partial remainder and are already below the divisor.
  assign trial     = {rem_r, quo_r[QW-1]};
  assign fits      = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CW'(1);
        if (cnt_r == CW'(QW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[QW+DW-1:QW];
      quo_r <= dividend[QW-1:0];
      den_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? trial_sub[DW-1:0] : trial[DW-1:0];
      quo_r <= {quo_r[QW-2:0], fits};
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  no_start_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start)
    else $error("divider restarted while busy");

endmodule

FILE: design/ramp_envelope_generator.sv
// Two-segment linear envelope: arm loads the registers, each tick of an
// active envelope advances the elapsed time by delta_ms and returns the
// new level, stop forces the level to unity. Every request returns exactly
// one result. A tick that interpolates is held up mainly by the shared
// restoring divider, which produces one quotient bit per cycle after a
// multiply step; every other request skips the multiply and divide.
// A result waiting in the output register does not hold off the next
// request. Registers may be written only while no request is in progress.
module ramp_envelope_generator #(
  parameter int TIME_BITS  = 16,
  parameter int LEVEL_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  renv_pkg::renv_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output renv_pkg::renv_out_t                   out_data,
  input  logic                                  cfg_wr_en,
  input  logic [renv_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [renv_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int PW    = LEVEL_BITS + TIME_BITS;
  localparam int SUM_W = (TIME_BITS > renv_pkg::DELTA_W ? TIME_BITS : renv_pkg::DELTA_W) + 1;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
  localparam logic [LEVEL_BITS-1:0] UNITY =
    (LEVEL_BITS > 12) ? LEVEL_BITS'(renv_pkg::UNITY_RAW) : LEVEL_MAX;
  localparam logic [SUM_W-1:0] TIME_MAX_EXT = SUM_W'({TIME_BITS{1'b1}});

  // Configuration registers.
  logic [LEVEL_BITS-1:0]            start_level_r;
  logic [LEVEL_BITS-1:0]            peak_level_r;
  logic [TIME_BITS-1:0]             rise_time_r;
  logic [TIME_BITS-1:0]             end_time_r;
  logic signed [renv_pkg::REPEAT_W-1:0] repeat_count_r;

  // Envelope state.
  logic [TIME_BITS-1:0]             elapsed_r;
  logic [LEVEL_BITS-1:0]            level_r;
  logic signed [renv_pkg::REPEAT_W-1:0] repeats_r;
  logic                             active_r;
  logic                             report_r;

  // Request and interpolation operands.
  logic [1:0]                       func_r;
  logic [renv_pkg::DELTA_W-1:0]     delta_r;
  logic [LEVEL_BITS-1:0]            lerp_a_r;
  logic [LEVEL_BITS-1:0]            lerp_diff_r;
  logic                             lerp_down_r;
  logic [TIME_BITS-1:0]             lerp_num_r;
  logic [TIME_BITS-1:0]             lerp_den_r;
  logic [PW-1:0]                    product_r;

  logic                             out_valid_r;
  renv_pkg::renv_out_t              out_data_r;

  renv_pkg::renv_state_t            state_r;
  renv_pkg::renv_state_t            state_nxt;

  logic                             div_start;
  logic [LEVEL_BITS-1:0]            div_quo;
  renv_pkg::renv_div_stat_t         div_stat;

  logic [SUM_W-1:0]                 time_sum;
  logic                             tick_act;
  logic                             in_rise;
  logic                             has_fall;
  logic                             in_fall;
  logic                             need_lerp;
  logic [LEVEL_BITS-1:0]            seg_a;
  logic [LEVEL_BITS-1:0]            seg_b;
  logic                             out_free;
  logic                             in_take;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign time_sum  = SUM_W'(elapsed_r) + SUM_W'(delta_r);
  assign tick_act  = (func_r == renv_pkg::FUNC_TICK) && active_r;
  assign in_rise   = elapsed_r < rise_time_r;
  assign has_fall  = end_time_r > rise_time_r;
  assign in_fall   = elapsed_r < end_time_r;
  assign need_lerp = tick_act && (in_rise || (has_fall && in_fall));
  assign seg_a     = in_rise ? start_level_r : peak_level_r;
  assign seg_b     = in_rise ? peak_level_r : start_level_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_level_r  <= '0;
      peak_level_r   <= LEVEL_BITS'(renv_pkg::UNITY_RAW);
      rise_time_r    <= '0;
      end_time_r     <= '0;
      repeat_count_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        renv_pkg::CFG_START_LEVEL:  start_level_r  <= LEVEL_BITS'(cfg_data);
        renv_pkg::CFG_PEAK_LEVEL:   peak_level_r   <= LEVEL_BITS'(cfg_data);
        renv_pkg::CFG_RISE_TIME:    rise_time_r    <= TIME_BITS'(cfg_data);
        renv_pkg::CFG_END_TIME:     end_time_r     <= TIME_BITS'(cfg_data);
        renv_pkg::CFG_REPEAT_COUNT: repeat_count_r <= cfg_data[renv_pkg::REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= renv_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      renv_pkg::ST_IDLE: if (in_valid) state_nxt = renv_pkg::ST_TIME;
      renv_pkg::ST_TIME: state_nxt = renv_pkg::ST_EVAL;
      renv_pkg::ST_EVAL: state_nxt = need_lerp ? renv_pkg::ST_MUL : renv_pkg::ST_OUT;
      renv_pkg::ST_MUL:  state_nxt = renv_pkg::ST_LOAD;
      renv_pkg::ST_LOAD: state_nxt = renv_pkg::ST_DIV;
      renv_pkg::ST_DIV:  if (div_stat.done) state_nxt = renv_pkg::ST_OUT;
      renv_pkg::ST_OUT:  if (out_free) state_nxt = renv_pkg::ST_IDLE;
      default:           state_nxt = renv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    div_start = 1'b0;
    case (state_r)
      renv_pkg::ST_IDLE: in_stall  = 1'b0;
      renv_pkg::ST_LOAD: div_start = 1'b1;
      default: ;
    endcase
  end

  // Envelope state and sequencing of one request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
      level_r   <= UNITY;
      repeats_r <= '0;
      active_r  <= 1'b0;
    end else begin
      case (state_r)
        renv_pkg::ST_TIME: begin
          if (tick_act) begin
            elapsed_r <= (time_sum > TIME_MAX_EXT) ? {TIME_BITS{1'b1}}
                                                   : time_sum[TIME_BITS-1:0];
          end
        end
        renv_pkg::ST_EVAL: begin
          case (func_r)
            renv_pkg::FUNC_TICK: begin
              if (tick_act && !need_lerp) begin
                level_r <= has_fall ? start_level_r : peak_level_r;
                // End of a cycle: restart while repeats remain.
                if (repeats_r != '0) begin
                  if (!repeats_r[renv_pkg::REPEAT_W-1]) begin
                    repeats_r <= repeats_r - renv_pkg::REPEAT_W'(1);
                  end
                  elapsed_r <= '0;
                end else begin
                  active_r <= 1'b0;
                end
              end
            end
            renv_pkg::FUNC_ARM: begin
              elapsed_r <= '0;
              level_r   <= (rise_time_r != '0) ? start_level_r : peak_level_r;
              repeats_r <= repeat_count_r;
              active_r  <= 1'b1;
            end
            renv_pkg::FUNC_STOP: begin
              active_r <= 1'b0;
              level_r  <= UNITY;
            end
            default: ;
          endcase
        end
        renv_pkg::ST_DIV: begin
          if (div_stat.done) begin
            level_r <= lerp_down_r ? (lerp_a_r - div_quo) : (lerp_a_r + div_quo);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      func_r  <= in_data.func;
      delta_r <= in_data.delta_ms;
    end
    if (state_r == renv_pkg::ST_EVAL) begin
      report_r    <= tick_act;
      lerp_a_r    <= seg_a;
      lerp_down_r <= seg_b < seg_a;
      lerp_diff_r <= (seg_b < seg_a) ? (seg_a - seg_b) : (seg_b - seg_a);
      lerp_num_r  <= in_rise ? elapsed_r : (elapsed_r - rise_time_r);
      lerp_den_r  <= in_rise ? rise_time_r : (end_time_r - rise_time_r);
    end
    if (state_r == renv_pkg::ST_MUL) begin
      product_r <= PW'(lerp_diff_r) * PW'(lerp_num_r);
    end
  end

  renv_div #(
    .QW(LEVEL_BITS),
    .DW(TIME_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product_r),
    .divisor  (lerp_den_r),
    .quotient (div_quo),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == renv_pkg::ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == renv_pkg::ST_OUT && out_free) begin
      out_data_r.level   <= renv_pkg::OUT_LEVEL_W'(level_r);
      out_data_r.report  <= report_r;
      out_data_r.running <= active_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  div_only_in_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    (div_stat.busy || div_stat.done) |-> state_r == renv_pkg::ST_DIV)
    else $error("divider active outside of the divide phase");

  quotient_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == renv_pkg::ST_DIV && div_stat.done) |-> div_quo <= lerp_diff_r)
    else $error("interpolation step exceeds the level span");

  pending_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == renv_pkg::ST_OUT && out_valid_r && out_stall) |=>
      state_r == renv_pkg::ST_OUT)
    else $error("result register overwritten while a result is pending");

  stop_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == renv_pkg::ST_EVAL && func_r == renv_pkg::FUNC_STOP) |=>
      (!active_r && level_r == UNITY))
    else $error("stop request did not halt the envelope");

endmodule

FILE: verif/envelope_checker.sv
module envelope_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  renv_pkg::renv_in_t               in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  renv_pkg::renv_out_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [renv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [renv_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               err_count,
  output int                               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Register copy as seen by the envelope.
  logic [15:0]       start_lvl;
  logic [15:0]       peak_lvl;
  logic [15:0]       rise_ms;
  logic [15:0]       end_ms;
  logic signed [7:0] repeat_cfg;

  // Envelope state.
  logic [15:0]       elapsed_ms;
  logic [15:0]       level_now;
  logic signed [7:0] repeats_left;
  logic              running_now;

  renv_pkg::renv_out_t due_levels[$];

  // Linear interpolation from a toward b; the truncated quotient rounds toward a.
  function automatic logic [15:0] interp_level(input logic [15:0] a, input logic [15:0] b,
                                               input logic [15:0] num, input logic [15:0] den);
    logic [31:0] span;
    if (den == 16'd0) begin
      return a;
    end
    if (b >= a) begin
      span = (32'(b - a) * 32'(num)) / 32'(den);
      return a + span[15:0];
    end
    span = (32'(a - b) * 32'(num)) / 32'(den);
    return a - span[15:0];
  endfunction

  task automatic close_cycle();
    if (repeats_left != 8'sd0) begin
      if (repeats_left > 8'sd0) begin
        repeats_left = repeats_left - 8'sd1;
      end
      elapsed_ms = 16'd0;
    end else begin
      running_now = 1'b0;
    end
  endtask

  task automatic step_envelope(input renv_pkg::renv_in_t req,
                               output renv_pkg::renv_out_t res);
    logic [16:0] sum;
    logic        rep;
    rep = 1'b0;
    case (req.func)
      renv_pkg::FUNC_TICK: begin
        if (running_now) begin
          rep = 1'b1;
          sum = {1'b0, elapsed_ms} + 17'(req.delta_ms);
          elapsed_ms = sum[16] ? 16'hFFFF : sum[15:0];
          if (elapsed_ms < rise_ms) begin
            level_now = interp_level(start_lvl, peak_lvl, elapsed_ms, rise_ms);
          end else if (end_ms > rise_ms) begin
            if (elapsed_ms < end_ms) begin
              level_now = interp_level(peak_lvl, start_lvl, elapsed_ms - rise_ms,
                                       end_ms - rise_ms);
            end else begin
              level_now = start_lvl;
              close_cycle();
            end
          end else begin
            level_now = peak_lvl;
            close_cycle();
          end
        end
      end
      renv_pkg::FUNC_ARM: begin
        elapsed_ms = 16'd0;
        level_now = (rise_ms != 16'd0) ? start_lvl : peak_lvl;
        repeats_left = repeat_cfg;
        running_now = 1'b1;
      end
      renv_pkg::FUNC_STOP: begin
        running_now = 1'b0;
        level_now = 16'(renv_pkg::UNITY_RAW);
      end
      default: begin
      end
    endcase
    res.level = level_now;
    res.report = rep;
    res.running = running_now;
  endtask

  task automatic report_mismatch(input string what, input renv_pkg::renv_out_t exp,
                                 input renv_pkg::renv_out_t got);
    err_count++;
    if (err_count <= 10) begin
      $display("%0t: %s: expected level %0d report %0b running %0b,", $time, what,
               exp.level, exp.report, exp.running);
      $display("    got level %0d report %0b running %0b", got.level, got.report,
               got.running);
    end
  endtask

  always @(posedge clk) begin
    renv_pkg::renv_out_t exp;
    renv_pkg::renv_out_t res;
    if (!rst_n) begin
      start_lvl = 16'd0;
      peak_lvl = 16'd4096;
      rise_ms = 16'd0;
      end_ms = 16'd0;
      repeat_cfg = 8'sd0;
      elapsed_ms = 16'd0;
      level_now = 16'(renv_pkg::UNITY_RAW);
      repeats_left = 8'sd0;
      running_now = 1'b0;
      due_levels.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          renv_pkg::CFG_START_LEVEL:  start_lvl = cfg_data[15:0];
          renv_pkg::CFG_PEAK_LEVEL:   peak_lvl = cfg_data[15:0];
          renv_pkg::CFG_RISE_TIME:    rise_ms = cfg_data[15:0];
          renv_pkg::CFG_END_TIME:     end_ms = cfg_data[15:0];
          renv_pkg::CFG_REPEAT_COUNT: repeat_cfg = cfg_data[7:0];
          default: begin
          end
        endcase
      end
      if (out_valid && !out_stall) begin
        if (due_levels.size() == 0) begin
          report_mismatch("result with no request outstanding", '0, out_data);
        end else begin
          exp = due_levels.pop_front();
          if (out_data.level !== exp.level || out_data.report !== exp.report ||
              out_data.running !== exp.running) begin
            report_mismatch("result mismatch", exp, out_data);
          end
        end
      end
      if (in_valid && !in_stall) begin
        step_envelope(in_data, res);
        due_levels.push_back(res);
      end
    end
    pending_count = due_levels.size();
  end

endmodule

FILE: verif/ramp_envelope_generator_test.sv
module ramp_envelope_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  renv_pkg::renv_in_t               in_data;
  logic                             out_valid;
  logic                             out_stall;
  renv_pkg::renv_out_t              out_data;
  logic                             cfg_wr_en;
  logic [renv_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [renv_pkg::CFG_DATA_W-1:0]  cfg_data;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  ramp_envelope_generator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  envelope_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .err_count     (mismatches),
    .pending_count (outstanding)
  );

  initial begin
    #2_000_000;
    $display("ramp_envelope_generator verification failed");
    $finish;
  end

  // Receiver side. A hold-off request keeps the result channel stalled for a
  // long counted stretch so that the block backs up into its input.
  initial begin
    int hold_served;
    int hold_left;
    hold_served = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_reqs) begin
        hold_served = hold_reqs;
        out_stall <= 1'b1;
        for (hold_left = 400; hold_left > 1; hold_left--) begin
          @(negedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  task automatic send_req(input logic [1:0] func, input logic [9:0] delta);
    renv_pkg::renv_in_t req;
    req.func = func;
    req.delta_ms = delta;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_cfg(input logic [renv_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [15:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic write_all(input logic [15:0] s_lvl, input logic [15:0] p_lvl,
                           input logic [15:0] rt, input logic [15:0] et,
                           input logic signed [7:0] reps);
    wait_idle();
    write_cfg(renv_pkg::CFG_START_LEVEL, s_lvl);
    write_cfg(renv_pkg::CFG_PEAK_LEVEL, p_lvl);
    write_cfg(renv_pkg::CFG_RISE_TIME, rt);
    write_cfg(renv_pkg::CFG_END_TIME, et);
    // The upper byte is don't-care for the repeat count.
    write_cfg(renv_pkg::CFG_REPEAT_COUNT, {8'($urandom), reps});
  endtask

  function automatic logic [15:0] pick_level();
    case ($urandom_range(7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'(renv_pkg::UNITY_RAW);
      default: return 16'($urandom);
    endcase
  endfunction

  // One armed envelope with random shape, random tick spacing and a little
  // noise (stops, re-arms, unused codes) mixed in.
  task automatic run_episode();
    int               shape;
    int               ticks;
    int               n;
    int               dlim;
    logic [15:0]      rt;
    logic [15:0]      et;
    logic [15:0]      span;
    logic [16:0]      et_wide;
    logic signed [7:0] reps;
    shape = $urandom_range(15);
    if (shape == 0) begin
      rt = 16'd0;
    end else if (shape == 1) begin
      rt = 16'hFFFF - 16'($urandom_range(700));
    end else if (shape == 2) begin
      rt = 16'($urandom);
    end else begin
      rt = 16'($urandom_range(3000));
    end
    case ($urandom_range(3))
      0: et = 16'($urandom_range(rt));
      1: et = rt;
      default: begin
        et_wide = 17'(rt) + 17'($urandom_range(3000));
        et = et_wide[16] ? 16'hFFFF : et_wide[15:0];
      end
    endcase
    // Long envelopes run into the top of the elapsed-time range.
    if (shape == 1) begin
      et = $urandom_range(1) ? 16'hFFFF : rt;
    end
    case ($urandom_range(7))
      0: reps = -8'sd1;
      1: reps = 8'($urandom_range(127));
      default: reps = 8'($urandom_range(3));
    endcase
    span = (et > rt) ? et : rt;
    dlim = span / 6 + 1;
    if (dlim > 1023) begin
      dlim = 1023;
    end
    ticks = (shape == 1) ? 70 + $urandom_range(10) : $urandom_range(40, 4);
    write_all(pick_level(), pick_level(), rt, et, reps);
    send_req(renv_pkg::FUNC_ARM, 10'($urandom));
    for (n = 0; n < ticks; n++) begin
      case ($urandom_range(31))
        0: send_req(renv_pkg::FUNC_STOP, 10'($urandom));
        1: send_req(FUNC_UNUSED, 10'($urandom));
        2: send_req(renv_pkg::FUNC_ARM, 10'($urandom));
        3: send_req(renv_pkg::FUNC_TICK, 10'($urandom));
        default: begin
          if (shape == 1) begin
            send_req(renv_pkg::FUNC_TICK, 10'h3FF);
          end else begin
            send_req(renv_pkg::FUNC_TICK, 10'($urandom_range(dlim)));
          end
        end
      endcase
    end
    if ($urandom_range(1)) begin
      send_req(renv_pkg::FUNC_STOP, 10'($urandom));
    end
  endtask

  initial begin
    int ph;
    int phase_goal;
    int guard;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests, starting from the reset register values.
    send_req(renv_pkg::FUNC_TICK, 10'h3FF);
    send_req(FUNC_UNUSED, 10'h2AA);
    send_req(renv_pkg::FUNC_ARM, 10'h155);
    send_req(renv_pkg::FUNC_TICK, 10'd0);
    send_req(renv_pkg::FUNC_STOP, 10'd0);
    write_all(16'd0, 16'hFFFF, 16'd1000, 16'd3000, 8'sd1);
    send_req(renv_pkg::FUNC_ARM, 10'd0);
    send_req(renv_pkg::FUNC_TICK, 10'd0);
    send_req(renv_pkg::FUNC_TICK, 10'h3FF);
    send_req(renv_pkg::FUNC_TICK, 10'd977);
    send_req(renv_pkg::FUNC_TICK, 10'd1000);
    send_req(renv_pkg::FUNC_TICK, 10'd500);
    repeat (3) send_req(renv_pkg::FUNC_TICK, 10'h3FF);
    send_req(renv_pkg::FUNC_TICK, 10'd7);
    write_all(16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, -8'sd1);
    send_req(renv_pkg::FUNC_ARM, 10'd0);
    send_req(renv_pkg::FUNC_TICK, 10'h3FF);
    send_req(renv_pkg::FUNC_STOP, 10'h3FF);
    send_req(renv_pkg::FUNC_ARM, 10'd0);
    send_req(renv_pkg::FUNC_ARM, 10'd0);
    write_all(16'd100, 16'd9000, 16'd0, 16'd1000, 8'sd0);
    send_req(renv_pkg::FUNC_ARM, 10'd0);
    send_req(renv_pkg::FUNC_TICK, 10'd5);
    send_req(renv_pkg::FUNC_TICK, 10'h3FF);

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          hold_reqs++;
        end
        1: begin
          send_idle_pct = 63;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 63;
        end
        default: begin
          send_idle_pct = 26;
          stall_pct = 26;
        end
      endcase
      phase_goal = sent + 375;
      while (sent < phase_goal) begin
        run_episode();
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    for (guard = 0; guard < 20000 && outstanding != 0; guard++) begin
      @(negedge clk);
    end
    repeat (40) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ramp_envelope_generator verification clean");
    end else begin
      $display("ramp_envelope_generator verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/renv_pkg.sv
design/renv_div.sv
design/ramp_envelope_generator.sv
verif/envelope_checker.sv
verif/ramp_envelope_generator_test.sv
